// ===== rtl/pbts_pkg.sv =====
// ----------------------------------------------------------------------------
// Plain bitmap tape store package
// Shared constants, codes and types for the plain bitmap tape store.
// ----------------------------------------------------------------------------
`default_nettype none

package pbts_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int STORE_DEPTH = 4096;
  localparam int MAX_TOKEN   = 70;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [1:0] ST_LOADING = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } pbts_wr_t;

  typedef struct packed {
    logic       ready;
    logic       error;
    logic [6:0] width;
    logic [6:0] height;
  } pbts_img_t;

endpackage

`default_nettype wire

// ===== rtl/pbts_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one feed or move item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbts_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        file_byte;
  logic              end_of_file;
  logic signed [6:0] target_row;
  logic signed [6:0] target_col;

  modport source (output valid, operation, file_byte, end_of_file, target_row, target_col,
                  input ready);
  modport sink (input valid, operation, file_byte, end_of_file, target_row, target_col,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/pbts_out_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] load_status;
  logic       move_ok;
  logic [7:0] cell_value;
  logic [5:0] last_col;
  logic [5:0] last_row;

  modport source (output valid, load_status, move_ok, cell_value, last_col, last_row,
                  input ready);
  modport sink (input valid, load_status, move_ok, cell_value, last_col, last_row,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/plain_bitmap_tape_store.sv =====
// ----------------------------------------------------------------------------
// Plain bitmap tape store
// Loads a P1 image into a pixel memory and serves head moves and cell reads.
// A request passes the read stage (s1), which registers the pixel memory read,
// and then the response register; s1 holds while a result waits untaken.
// Throughput: one item per cycle while the response side takes results; the
// registered memory read sets the two-stage path, and the response register
// lets a new item enter while a result waits.
// Reset clears the parser, head and pipeline; the pixel memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module plain_bitmap_tape_store (
  input wire logic  clk,
  input wire logic  rst,
  pbts_in_if.sink   req,
  pbts_out_if.source rsp
);
  import pbts_pkg::*;

  pbts_wr_t          wr;
  pbts_img_t         img;
  logic              accept;
  logic              move_ok;
  logic [12:0]       lin;
  logic [5:0]        head_row;
  logic [5:0]        head_col;
  logic [7:0]        cur_cell;
  logic [7:0]        rdata;
  logic              s1_valid;
  logic              s1_ok;
  logic              s1_adv;
  logic [7:0]        mem [STORE_DEPTH];

  assign accept = req.valid && req.ready;
  assign s1_adv = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  assign move_ok = accept && req.operation && img.ready &&
                   !req.target_row[6] && !req.target_col[6] &&
                   ({1'b0, req.target_row[5:0]} < img.height) &&
                   ({1'b0, req.target_col[5:0]} < img.width);

  assign lin = 13'(13'(req.target_row[5:0]) * 13'(img.width) + 13'(req.target_col[5:0]));

  pbts_loader u_loader (
    .clk         (clk),
    .rst         (rst),
    .feed        (accept && !req.operation),
    .file_byte   (req.file_byte),
    .end_of_file (req.end_of_file),
    .wr          (wr),
    .img         (img)
  );

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (move_ok) begin
      rdata <= mem[lin[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_row <= '0;
      head_col <= '0;
    end else if (move_ok) begin
      head_row <= req.target_row[5:0];
      head_col <= req.target_col[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == '0) begin
      cur_cell <= wr.data;
    end else if (s1_adv && s1_ok) begin
      cur_cell <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok <= move_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.load_status <= img.ready ? ST_READY : (img.error ? ST_ERROR : ST_LOADING);
      rsp.move_ok     <= s1_ok;
      rsp.cell_value  <= img.ready ? (s1_ok ? rdata : cur_cell) : 8'd0;
      rsp.last_col    <= img.ready ? 6'(img.width - 7'd1) : 6'd0;
      rsp.last_row    <= img.ready ? 6'(img.height - 7'd1) : 6'd0;
    end
  end

  a_ok_needs_ready: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.move_ok |-> rsp.load_status == ST_READY)
    else $error("move_ok reported without a ready image");

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !img.ready)
    else $error("pixel write after the image became ready");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item did not reach the read stage");

  a_head_in_limits: assert property (@(posedge clk) disable iff (rst)
    img.ready |-> ({1'b0, head_row} < img.height) && ({1'b0, head_col} < img.width))
    else $error("head outside the image limits");

endmodule

`default_nettype wire

// ===== rtl/pbts_loader.sv =====
// ----------------------------------------------------------------------------
// P1 loader
// Parses the image file one byte per feed and issues pixel store writes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_loader (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              feed,
  input  wire logic [7:0]        file_byte,
  input  wire logic              end_of_file,
  output pbts_pkg::pbts_wr_t     wr,
  output pbts_pkg::pbts_img_t    img
);
  import pbts_pkg::*;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_PIXELS = 3'd3;
  localparam logic [2:0] PH_READY  = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  localparam logic [1:0] NS_START = 2'd0;
  localparam logic [1:0] NS_POS   = 2'd1;
  localparam logic [1:0] NS_NEG   = 2'd2;
  localparam logic [1:0] NS_STOP  = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_P     = 8'h50;

  logic [2:0]  phase, phase_next;
  logic [6:0]  tok_len, tok_len_next;
  logic        magic_found, magic_found_next;
  logic        prev_p, prev_p_next;
  logic        in_comment, in_comment_next;
  logic [1:0]  num_state, num_state_next;
  logic [7:0]  acc, acc_next;
  logic [6:0]  width, width_next;
  logic [6:0]  height, height_next;
  logic [12:0] area, area_next;
  logic [12:0] pix_count, pix_count_next;

  always_comb begin
    logic        blank;
    logic        found;
    logic        do_fin;
    logic [1:0]  fin_ns;
    logic [7:0]  fin_acc;
    logic [7:0]  v;
    logic [6:0]  len_inc;
    logic [9:0]  t;
    logic [13:0] prod;
    logic [12:0] cnt_inc;

    phase_next       = phase;
    tok_len_next     = tok_len;
    magic_found_next = magic_found;
    prev_p_next      = prev_p;
    in_comment_next  = in_comment;
    num_state_next   = num_state;
    acc_next         = acc;
    width_next       = width;
    height_next      = height;
    area_next        = area;
    pix_count_next   = pix_count;
    wr.en            = 1'b0;
    wr.addr          = pix_count[ADDR_W-1:0];
    wr.data          = file_byte;

    blank   = (file_byte == CH_SPACE) || (file_byte >= CH_TAB && file_byte <= CH_CR);
    found   = magic_found | (prev_p && file_byte == CH_ONE);
    len_inc = 7'(tok_len + 7'd1);
    cnt_inc = 13'(pix_count + 13'd1);
    do_fin  = 1'b0;
    fin_ns  = num_state;
    fin_acc = acc;
    t       = '0;
    v       = '0;
    prod    = '0;

    if (file_byte == CH_NUL) begin
      phase_next = PH_ERROR;
    end else begin
      unique case (phase) inside
        PH_MAGIC: begin
          if (blank) begin
            phase_next     = magic_found ? PH_WIDTH : PH_ERROR;
            tok_len_next   = '0;
            num_state_next = NS_START;
            acc_next       = '0;
          end else begin
            magic_found_next = found;
            prev_p_next      = (file_byte == CH_P);
            tok_len_next     = len_inc;
            if (len_inc >= 7'(MAX_TOKEN)) begin
              phase_next     = found ? PH_WIDTH : PH_ERROR;
              tok_len_next   = '0;
              num_state_next = NS_START;
              acc_next       = '0;
            end
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (in_comment || file_byte == CH_HASH) begin
            in_comment_next = !(file_byte == CH_LF || file_byte == CH_CR);
          end else if (blank) begin
            do_fin = 1'b1;
          end else begin
            if (num_state == NS_START && file_byte == CH_MINUS) begin
              fin_ns = NS_NEG;
            end else if (num_state == NS_START && file_byte == CH_PLUS) begin
              fin_ns = NS_POS;
            end else if (num_state == NS_START || num_state == NS_POS) begin
              if (file_byte >= CH_ZERO && file_byte <= CH_NINE) begin
                t = ({2'b00, acc} << 3) + ({2'b00, acc} << 1) +
                    10'(file_byte - CH_ZERO);
                fin_acc = (t > 10'(MAX_SIDE + 1)) ? 8'(MAX_SIDE + 1) : t[7:0];
                fin_ns  = NS_POS;
              end else begin
                fin_ns = NS_STOP;
              end
            end
            num_state_next = fin_ns;
            acc_next       = fin_acc;
            tok_len_next   = len_inc;
            do_fin         = (len_inc >= 7'(MAX_TOKEN));
          end
          if (do_fin) begin
            v = (fin_ns == NS_NEG) ? 8'd0 : fin_acc;
            if (v == 8'd0 || v > 8'(MAX_SIDE)) begin
              phase_next = PH_ERROR;
            end else begin
              tok_len_next   = '0;
              num_state_next = NS_START;
              acc_next       = '0;
              if (phase == PH_WIDTH) begin
                width_next = v[6:0];
                phase_next = PH_HEIGHT;
              end else begin
                height_next = v[6:0];
                prod        = 14'(width) * 14'(v[6:0]);
                if (prod > 14'(STORE_DEPTH)) begin
                  phase_next = PH_ERROR;
                end else begin
                  phase_next     = PH_PIXELS;
                  area_next      = prod[12:0];
                  pix_count_next = '0;
                end
              end
            end
          end
        end
        PH_PIXELS: begin
          if (!blank) begin
            wr.en          = 1'b1;
            pix_count_next = cnt_inc;
            if (cnt_inc >= area) begin
              phase_next = PH_READY;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (end_of_file && phase_next != PH_READY) begin
      phase_next = PH_ERROR;
    end

    if (!feed || phase == PH_READY || phase == PH_ERROR) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      tok_len     <= '0;
      magic_found <= 1'b0;
      prev_p      <= 1'b0;
      in_comment  <= 1'b0;
      num_state   <= NS_START;
      acc         <= '0;
      width       <= '0;
      height      <= '0;
      area        <= '0;
      pix_count   <= '0;
    end else if (feed && phase != PH_READY && phase != PH_ERROR) begin
      phase       <= phase_next;
      tok_len     <= tok_len_next;
      magic_found <= magic_found_next;
      prev_p      <= prev_p_next;
      in_comment  <= in_comment_next;
      num_state   <= num_state_next;
      acc         <= acc_next;
      width       <= width_next;
      height      <= height_next;
      area        <= area_next;
      pix_count   <= pix_count_next;
    end
  end

  assign img.ready  = (phase == PH_READY);
  assign img.error  = (phase == PH_ERROR);
  assign img.width  = width;
  assign img.height = height;

endmodule

`default_nettype wire
